[design/vpf_pkg.sv]
// Shared constants, types and register codes for the voxel persistence point filter.
package vpf_pkg;

  localparam int GRID_DIM    = 64;
  localparam int MAX_HISTORY = 16;

  localparam int GRID_W = $clog2(GRID_DIM);
  localparam int CELLS  = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int CELL_W = $clog2(CELLS);
  localparam int RUN_W  = $clog2(MAX_HISTORY + 1);
  localparam int HLEN_W = 5;
  localparam int LEN_W  = ((RUN_W > HLEN_W) ? RUN_W : HLEN_W) + 1;

  localparam int COORD_W  = 16;
  localparam int SQ_W     = 2 * COORD_W - 1;
  localparam int RANGE_W  = 32;
  localparam int INV_W    = 16;
  localparam int PROD_W   = COORD_W + INV_W + 1;
  localparam int SCALED_W = PROD_W - INV_W + 1;
  localparam int FRAME_W  = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OFIFO_DEPTH = 4;
  localparam int OPTR_W      = $clog2(OFIFO_DEPTH);
  localparam int OCNT_W      = $clog2(OFIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RANGE_SQ    = 3'd0,
    REG_MAX_RANGE_SQ    = 3'd1,
    REG_INV_VOXEL_SIZE  = 3'd2,
    REG_HISTORY_LEN     = 3'd3,
    REG_REMOVAL_ENABLED = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      frame_done;
  } out_item_t;

  typedef struct packed {
    logic [RANGE_W-1:0] min_range_sq;
    logic [RANGE_W-1:0] max_range_sq;
    logic [INV_W-1:0]   inv_voxel_size;
    logic [HLEN_W-1:0]  history_len;
    logic               removal_enabled;
  } cfg_t;

  // One classified request handed from the front to the back
  typedef struct packed {
    logic                      frame_end;
    logic                      advance;
    logic                      bypass;
    logic                      in_grid;
    logic [CELL_W-1:0]         vox_idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } q_entry_t;

  typedef struct packed {
    logic [FRAME_W-1:0] last;
    logic [RUN_W-1:0]   run;
  } hist_t;

endpackage

[design/vpf_front.sv]
// Front end: accepts requests, squares and scales coordinates, classifies and enqueues.
module vpf_front (
  input  logic             clk,
  input  logic             rst_n,
  input  vpf_pkg::cfg_t    cfg,
  input  logic             clearing,
  input  logic             in_valid,
  output logic             in_stall,
  input  vpf_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output vpf_pkg::q_entry_t q_data
);

  localparam int GW = vpf_pkg::GRID_W;
  localparam int CW = vpf_pkg::CELL_W;

  logic a_valid_r;
  logic a_func_r;
  logic a_adv_r;
  logic a_bypass_r;
  logic has_pts_r;
  logic signed [vpf_pkg::COORD_W-1:0] a_x_r, a_y_r, a_z_r;
  logic [vpf_pkg::SQ_W-1:0] a_sqx_r, a_sqy_r, a_sqz_r;
  logic signed [vpf_pkg::PROD_W-1:0] a_px_r, a_py_r, a_pz_r;

  logic [vpf_pkg::SQ_W-1:0] sqx, sqy, sqz;
  logic signed [vpf_pkg::PROD_W-1:0] px, py, pz;
  logic signed [vpf_pkg::INV_W:0] inv_s;
  logic accept;
  logic advance;
  logic [vpf_pkg::RANGE_W-1:0] r2;
  logic range_ok;
  logic [GW:0] ax, ay, az;

  // Returns {in range, grid index} for one scaled coordinate
  function automatic logic [GW:0] axis_index(input logic signed [vpf_pkg::PROD_W-1:0] prod);
    logic [vpf_pkg::SCALED_W-1:0] v;
    logic ok;
    v  = {prod[vpf_pkg::PROD_W-1], prod[vpf_pkg::PROD_W-1:vpf_pkg::INV_W]}
         + vpf_pkg::SCALED_W'(vpf_pkg::GRID_DIM / 2);
    ok = !v[vpf_pkg::SCALED_W-1] && (v < vpf_pkg::SCALED_W'(vpf_pkg::GRID_DIM));
    return {ok, v[GW-1:0]};
  endfunction

  assign advance  = !(a_valid_r && q_full);
  assign in_stall = clearing || !advance;
  assign accept   = in_valid && !in_stall;

  assign inv_s = {1'b0, cfg.inv_voxel_size};
  assign sqx   = in_data.pos_x * in_data.pos_x;
  assign sqy   = in_data.pos_y * in_data.pos_y;
  assign sqz   = in_data.pos_z * in_data.pos_z;
  assign px    = in_data.pos_x * inv_s;
  assign py    = in_data.pos_y * inv_s;
  assign pz    = in_data.pos_z * inv_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      has_pts_r <= 1'b0;
    end else begin
      if (advance) begin
        a_valid_r <= accept;
      end
      if (accept) begin
        if (in_data.func) begin
          has_pts_r <= 1'b0;
        end else if (cfg.removal_enabled) begin
          has_pts_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_func_r   <= in_data.func;
      a_adv_r    <= cfg.removal_enabled && has_pts_r;
      a_bypass_r <= !cfg.removal_enabled;
      a_x_r      <= in_data.pos_x;
      a_y_r      <= in_data.pos_y;
      a_z_r      <= in_data.pos_z;
      a_sqx_r    <= sqx;
      a_sqy_r    <= sqy;
      a_sqz_r    <= sqz;
      a_px_r     <= px;
      a_py_r     <= py;
      a_pz_r     <= pz;
    end
  end

  assign r2 = vpf_pkg::RANGE_W'(a_sqx_r) + vpf_pkg::RANGE_W'(a_sqy_r)
            + vpf_pkg::RANGE_W'(a_sqz_r);
  assign range_ok = (r2 >= cfg.min_range_sq) && (r2 <= cfg.max_range_sq);

  assign ax = axis_index(a_px_r);
  assign ay = axis_index(a_py_r);
  assign az = axis_index(a_pz_r);

  // Drop out-of-range points here; frame ends always go through
  assign q_push = a_valid_r && !q_full && (a_func_r || range_ok);

  always_comb begin
    q_data.frame_end = a_func_r;
    q_data.advance   = a_adv_r;
    q_data.bypass    = a_bypass_r;
    q_data.in_grid   = ax[GW] && ay[GW] && az[GW];
    q_data.vox_idx   = (CW'(ax[GW-1:0]) * CW'(vpf_pkg::GRID_DIM) + CW'(ay[GW-1:0]))
                       * CW'(vpf_pkg::GRID_DIM) + CW'(az[GW-1:0]);
    q_data.x         = a_x_r;
    q_data.y         = a_y_r;
    q_data.z         = a_z_r;
  end

endmodule

[design/vpf_queue.sv]
// Short request queue between the front end and the voxel store back end.
module vpf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  vpf_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output vpf_pkg::q_entry_t pop_data
);

  vpf_pkg::q_entry_t slots_r [vpf_pkg::QUEUE_DEPTH];
  logic [vpf_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [vpf_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == vpf_pkg::QCNT_W'(vpf_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == vpf_pkg::QPTR_W'(vpf_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == vpf_pkg::QPTR_W'(vpf_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[design/vpf_back.sv]
// Back end: voxel history store with read-modify-write, frame state and result buffer.
module vpf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  vpf_pkg::cfg_t     cfg,
  output logic              clearing,
  input  logic              q_empty,
  input  vpf_pkg::q_entry_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output vpf_pkg::out_item_t out_data
);

  localparam int LW = vpf_pkg::LEN_W;
  localparam int RW = vpf_pkg::RUN_W;

  vpf_pkg::hist_t store [vpf_pkg::CELLS];

  logic                        clr_busy_r;
  logic [vpf_pkg::CELL_W-1:0]  clr_addr_r;

  logic                        rd_valid_r;
  vpf_pkg::q_entry_t           rd_e_r;
  vpf_pkg::hist_t              rd_hist_r;

  logic                        fwd_valid_r;
  logic [vpf_pkg::CELL_W-1:0]  fwd_addr_r;
  vpf_pkg::hist_t              fwd_data_r;

  logic [vpf_pkg::FRAME_W-1:0] frame_number_r, frame_prev_r;
  logic [RW-1:0]               frames_seen_r;

  vpf_pkg::out_item_t          ofifo_r [vpf_pkg::OFIFO_DEPTH];
  logic [vpf_pkg::OPTR_W-1:0]  o_wr_r, o_rd_r;
  logic [vpf_pkg::OCNT_W-1:0]  o_cnt_r, o_cnt_nxt;

  vpf_pkg::hist_t              old_h, new_h;
  vpf_pkg::out_item_t          res;
  logic                        fresh, cont, warm, keep, store_wr, o_push, o_pop;
  logic [LW-1:0]               hl, len;
  logic [vpf_pkg::OCNT_W:0]    in_flight;

  assign clearing = clr_busy_r;

  // Pop only with room left in the result buffer for everything in flight
  assign in_flight = (vpf_pkg::OCNT_W + 1)'(o_cnt_r) + (vpf_pkg::OCNT_W + 1)'(rd_valid_r);
  assign q_pop = !q_empty && !clr_busy_r
                 && (in_flight < (vpf_pkg::OCNT_W + 1)'(vpf_pkg::OFIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == vpf_pkg::CELL_W'(vpf_pkg::CELLS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    old_h = (fwd_valid_r && fwd_addr_r == rd_e_r.vox_idx) ? fwd_data_r : rd_hist_r;
    fresh = (old_h.run == '0) || (old_h.last != frame_number_r);
    cont  = (old_h.run != '0) && (old_h.last == frame_prev_r);
    new_h = old_h;
    if (fresh) begin
      new_h.last = frame_number_r;
      if (!cont) begin
        new_h.run = RW'(1);
      end else if (old_h.run < RW'(vpf_pkg::MAX_HISTORY)) begin
        new_h.run = old_h.run + 1'b1;
      end
    end

    hl   = LW'(cfg.history_len);
    len  = (hl < LW'(vpf_pkg::MAX_HISTORY)) ? hl : LW'(vpf_pkg::MAX_HISTORY);
    warm = (LW'(frames_seen_r) + 1'b1 < len) || (len == '0);

    store_wr = rd_valid_r && !rd_e_r.frame_end && !rd_e_r.bypass && rd_e_r.in_grid;

    if (rd_e_r.frame_end || rd_e_r.bypass) begin
      keep = 1'b1;
    end else begin
      keep = warm || (rd_e_r.in_grid && LW'(new_h.run) >= len);
    end
    o_push = rd_valid_r && keep;

    if (rd_e_r.frame_end) begin
      res.out_x      = '0;
      res.out_y      = '0;
      res.out_z      = '0;
      res.frame_done = 1'b1;
    end else begin
      res.out_x      = rd_e_r.x;
      res.out_y      = rd_e_r.y;
      res.out_z      = rd_e_r.z;
      res.frame_done = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      store[clr_addr_r] <= '0;
    end else if (store_wr) begin
      store[rd_e_r.vox_idx] <= new_h;
    end
    rd_hist_r <= store[q_data.vox_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r     <= 1'b0;
      fwd_valid_r    <= 1'b0;
      frame_number_r <= '0;
      frame_prev_r   <= '1;
      frames_seen_r  <= '0;
    end else begin
      rd_valid_r  <= q_pop;
      fwd_valid_r <= store_wr;
      if (rd_valid_r && rd_e_r.frame_end && rd_e_r.advance) begin
        frame_number_r <= frame_number_r + 1'b1;
        frame_prev_r   <= frame_number_r;
        if (frames_seen_r < RW'(vpf_pkg::MAX_HISTORY)) begin
          frames_seen_r <= frames_seen_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_e_r <= q_data;
    end
    fwd_addr_r <= rd_e_r.vox_idx;
    fwd_data_r <= new_h;
  end

  assign out_valid = (o_cnt_r != '0);
  assign out_data  = ofifo_r[o_rd_r];
  assign o_pop     = out_valid && !out_stall;

  always_comb begin
    o_cnt_nxt = o_cnt_r;
    if (o_push && !o_pop) begin
      o_cnt_nxt = o_cnt_r + 1'b1;
    end else if (o_pop && !o_push) begin
      o_cnt_nxt = o_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_wr_r  <= '0;
      o_rd_r  <= '0;
      o_cnt_r <= '0;
    end else begin
      o_cnt_r <= o_cnt_nxt;
      if (o_push) begin
        o_wr_r <= (o_wr_r == vpf_pkg::OPTR_W'(vpf_pkg::OFIFO_DEPTH - 1)) ? '0 : o_wr_r + 1'b1;
      end
      if (o_pop) begin
        o_rd_r <= (o_rd_r == vpf_pkg::OPTR_W'(vpf_pkg::OFIFO_DEPTH - 1)) ? '0 : o_rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      ofifo_r[o_wr_r] <= res;
    end
  end

endmodule

[design/voxel_persistence_point_filter.sv]
// Top level: configuration registers and the front, queue and back end of the filter.
// Usage:
//   in_*  : point and end-of-frame requests; taken when in_valid is high and in_stall low.
//   out_* : kept points and one end-of-frame result per frame marker; taken when out_valid
//           is high and out_stall low. The result payload holds steady while stalled.
//   cfg_* : register writes (index, data); cfg_ready is always high. Write only while idle.
// Throughput: one request per cycle unless stalled. The voxel store reads one entry and
//   writes one a cycle, previous write forwarded; that read-modify-write loop sets the rate.
// Path: a request is registered at the input, then passes the queue, the store read stage
//   and the result buffer, and waits longer if the queue or result buffer is backed up.
// Reset: frame counters and handshakes clear at once; the voxel store is then cleared one
//   entry a cycle through every cell, during which in_stall stays high.
// Receiver stall: a four-entry result buffer absorbs results; once it fills the back end
//   stops drawing from the queue, the queue fills and in_stall rises, with no request lost.
// Out-of-range points and points not kept produce no result.
module voxel_persistence_point_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  vpf_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output vpf_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vpf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  vpf_pkg::cfg_t     cfg_r;
  vpf_pkg::q_entry_t push_data, pop_data;
  logic              q_push, q_pop, q_full, q_empty, clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_range_sq    <= vpf_pkg::RANGE_W'(250000);
      cfg_r.max_range_sq    <= vpf_pkg::RANGE_W'(16000000);
      cfg_r.inv_voxel_size  <= vpf_pkg::INV_W'(655);
      cfg_r.history_len     <= vpf_pkg::HLEN_W'(3);
      cfg_r.removal_enabled <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (vpf_pkg::cfg_reg_t'(cfg_index))
        vpf_pkg::REG_MIN_RANGE_SQ:    cfg_r.min_range_sq    <= cfg_wdata;
        vpf_pkg::REG_MAX_RANGE_SQ:    cfg_r.max_range_sq    <= cfg_wdata;
        vpf_pkg::REG_INV_VOXEL_SIZE:  cfg_r.inv_voxel_size  <= cfg_wdata[vpf_pkg::INV_W-1:0];
        vpf_pkg::REG_HISTORY_LEN:     cfg_r.history_len     <= cfg_wdata[vpf_pkg::HLEN_W-1:0];
        vpf_pkg::REG_REMOVAL_ENABLED: cfg_r.removal_enabled <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  vpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .clearing (clearing),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  vpf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (pop_data)
  );

  vpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .clearing  (clearing),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
